// ===== rtl/core/stea_pkg.sv =====
// ----------------------------------------------------------------------------
// stea_pkg
// Shared widths, types and codes of the structure tensor eigen analysis block.
// ----------------------------------------------------------------------------
package stea_pkg;

  localparam int IN_W      = 32;
  localparam int MAJ_W     = 33;
  localparam int ANIS_W    = 17;
  localparam int VEC_W     = 16;
  localparam int IN_DATA_W = 96;
  localparam int OUT_DATA_W = 120;

  // square root chain: two radicand bits per cell
  localparam int SQ_CELLS = 33;
  localparam int RAD_W    = 2 * SQ_CELLS;
  localparam int ROOT_W   = SQ_CELLS;
  localparam int REM_W    = ROOT_W + 2;

  // restoring divider chain: one quotient bit per cell
  localparam int DIV_CELLS = 16;
  localparam int DIV_W     = 34;
  localparam int Q_W       = DIV_CELLS;

  localparam int MAG_W  = 35;
  localparam int NORM_W = 31;

  typedef enum logic [1:0] {
    ANIS_ZERO,
    ANIS_FULL,
    ANIS_DIV
  } anis_mode_t;

  typedef struct packed {
    logic [IN_W-1:0]        a;
    logic [IN_W-1:0]        b;
    logic signed [IN_W-1:0] c;
    logic                   le;
    logic                   fe;
  } side_a_t;

  typedef struct packed {
    logic [MAJ_W-1:0]        major;
    logic signed [MAJ_W-1:0] minor;
    logic [ROOT_W-1:0]       s;
    logic [MAJ_W-1:0]        t;
    logic                    nx;
    logic                    ny;
    logic [NORM_W-1:0]       mx;
    logic [NORM_W-1:0]       my;
    logic                    le;
    logic                    fe;
  } side_b_t;

  typedef struct packed {
    logic [MAJ_W-1:0]        major;
    logic signed [MAJ_W-1:0] minor;
    logic                    nx;
    logic                    ny;
    logic                    nzero;
    anis_mode_t              mode;
    logic                    le;
    logic                    fe;
  } side_c_t;

  typedef struct packed {
    logic [OUT_DATA_W-1:0] data;
    logic                  le;
    logic                  fe;
  } out_rec_t;

endpackage

// ===== rtl/core/stea_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// stea_sqrt_cell
// One digit step of a pipelined restoring square root: two radicand bits in,
// one root bit out, registered.
// ----------------------------------------------------------------------------
module stea_sqrt_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [stea_pkg::RAD_W-1:0]    rad_i,
  input  logic [stea_pkg::ROOT_W-1:0]   root_i,
  input  logic [stea_pkg::REM_W-1:0]    rem_i,
  output logic [stea_pkg::RAD_W-1:0]    rad_o,
  output logic [stea_pkg::ROOT_W-1:0]   root_o,
  output logic [stea_pkg::REM_W-1:0]    rem_o
);

  logic [stea_pkg::RAD_W-1:0]   rad_r,  rad_nxt;
  logic [stea_pkg::ROOT_W-1:0]  root_r, root_nxt;
  logic [stea_pkg::REM_W-1:0]   rem_r,  rem_nxt;
  logic [stea_pkg::REM_W+1:0]   part;
  logic [stea_pkg::REM_W+1:0]   trial;
  logic [stea_pkg::REM_W+1:0]   diff;
  logic                         ge;

  always_comb begin
    part     = {rem_i, rad_i[stea_pkg::RAD_W-1 -: 2]};
    trial    = {{(stea_pkg::REM_W - stea_pkg::ROOT_W){1'b0}}, root_i, 2'b01};
    diff     = part - trial;
    ge       = (part >= trial);
    rem_nxt  = ge ? diff[stea_pkg::REM_W-1:0] : part[stea_pkg::REM_W-1:0];
    root_nxt = {root_i[stea_pkg::ROOT_W-2:0], ge};
    rad_nxt  = {rad_i[stea_pkg::RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign rad_o  = rad_r;
  assign root_o = root_r;
  assign rem_o  = rem_r;

endmodule

// ===== rtl/core/stea_div_cell.sv =====
// ----------------------------------------------------------------------------
// stea_div_cell
// One step of a pipelined restoring divider: one dividend bit in, one
// quotient bit out, registered.
// ----------------------------------------------------------------------------
module stea_div_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [stea_pkg::DIV_W-1:0]  rem_i,
  input  logic [stea_pkg::Q_W-1:0]    low_i,
  input  logic [stea_pkg::DIV_W-1:0]  dvs_i,
  input  logic [stea_pkg::Q_W-1:0]    q_i,
  output logic [stea_pkg::DIV_W-1:0]  rem_o,
  output logic [stea_pkg::Q_W-1:0]    low_o,
  output logic [stea_pkg::DIV_W-1:0]  dvs_o,
  output logic [stea_pkg::Q_W-1:0]    q_o
);

  logic [stea_pkg::DIV_W-1:0] rem_r, rem_nxt;
  logic [stea_pkg::Q_W-1:0]   low_r, low_nxt;
  logic [stea_pkg::DIV_W-1:0] dvs_r;
  logic [stea_pkg::Q_W-1:0]   q_r, q_nxt;
  logic [stea_pkg::DIV_W:0]   part;
  logic [stea_pkg::DIV_W:0]   diff;
  logic                       ge;

  always_comb begin
    part    = {rem_i, low_i[stea_pkg::Q_W-1]};
    diff    = part - {1'b0, dvs_i};
    ge      = (part >= {1'b0, dvs_i});
    rem_nxt = ge ? diff[stea_pkg::DIV_W-1:0] : part[stea_pkg::DIV_W-1:0];
    low_nxt = {low_i[stea_pkg::Q_W-2:0], 1'b0};
    q_nxt   = {q_i[stea_pkg::Q_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      dvs_r <= dvs_i;
      q_r   <= q_nxt;
    end
  end

  assign rem_o = rem_r;
  assign low_o = low_r;
  assign dvs_o = dvs_r;
  assign q_o   = q_r;

endmodule

// ===== rtl/core/structure_tensor_eigen_analysis_top.sv =====
// ----------------------------------------------------------------------------
// structure_tensor_eigen_analysis_top
// Eigenvalues, anisotropy and minor eigenvector of a 2x2 structure tensor.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one tensor item per pixel; in_tdata = {xy, yy, xx}, xx lowest.
//           in_tlast carries the row end, in_tuser the frame end.
//   out_* : one result item per input item, same order; markers pass along.
// Throughput: one item per cycle while out_tready stays high.
// Path: from input accept to out_tvalid an item passes three input
//   stages, a 33-cell square root chain for the eigenvalue spread, four
//   vector stages, a second 33-cell square root chain for the vector norm,
//   one setup stage, a 16-cell divider chain (x, y and anisotropy lanes)
//   and the output register.
// Reset: rst_n low empties every stage; no item is invented.
// Stall: a skid register behind the output register takes one more item
//   while out_tready is low; the pipeline then freezes and in_tready drops
//   until the skid register drains. in_tready is a register output.
// ----------------------------------------------------------------------------
module structure_tensor_eigen_analysis_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [stea_pkg::IN_DATA_W-1:0]       in_tdata,  // tensor_xx, tensor_yy, tensor_xy
  input  logic                                 in_tlast,  // line_end
  input  logic                                 in_tuser,  // frame_end
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [stea_pkg::OUT_DATA_W-1:0]      out_tdata, // lambda_major, lambda_minor,
                                                          // anisotropy_out, eigvec_x,
                                                          // eigvec_y, zero pad
  output logic                                 out_tlast, // line_end_out
  output logic                                 out_tuser  // frame_end_out
);

  localparam int SQ  = stea_pkg::SQ_CELLS;
  localparam int DV  = stea_pkg::DIV_CELLS;

  logic en;
  logic skid_v_r;
  logic out_v_r;
  stea_pkg::out_rec_t out_rec_r, skid_rec_r, up_rec;

  assign en = ~skid_v_r;
  assign in_tready = en;

  // ---------------- input stages
  logic              v1_r, v2_r, v3_r;
  stea_pkg::side_a_t sa1_r, sa2_r, sa3_r, sa_in;
  logic [31:0]       dab, cmag;
  logic [63:0]       d2_r, c2_r;
  logic [stea_pkg::RAD_W-1:0] rad3_r;

  always_comb begin
    sa_in.a  = in_tdata[31:0];
    sa_in.b  = in_tdata[63:32];
    sa_in.c  = in_tdata[95:64];
    sa_in.le = in_tlast;
    sa_in.fe = in_tuser;
    dab  = (sa1_r.a >= sa1_r.b) ? (sa1_r.a - sa1_r.b) : (sa1_r.b - sa1_r.a);
    cmag = sa1_r.c[31] ? (32'd0 - sa1_r.c) : sa1_r.c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa1_r  <= sa_in;
      sa2_r  <= sa1_r;
      d2_r   <= 64'(dab) * 64'(dab);
      c2_r   <= 64'(cmag) * 64'(cmag);
      sa3_r  <= sa2_r;
      rad3_r <= stea_pkg::RAD_W'(d2_r) + {c2_r, 2'b00};
    end
  end

  // ---------------- square root chain for the spread s
  logic [stea_pkg::RAD_W-1:0]  ra_rad  [SQ+1];
  logic [stea_pkg::ROOT_W-1:0] ra_root [SQ+1];
  logic [stea_pkg::REM_W-1:0]  ra_rem  [SQ+1];
  stea_pkg::side_a_t           sa_dly_r [SQ];
  logic                        va_r     [SQ];

  assign ra_rad[0]  = rad3_r;
  assign ra_root[0] = '0;
  assign ra_rem[0]  = '0;

  for (genvar i = 0; i < SQ; i++) begin : g_sqa
    stea_sqrt_cell u_cell (
      .clk    (clk),
      .en     (en),
      .rad_i  (ra_rad[i]),
      .root_i (ra_root[i]),
      .rem_i  (ra_rem[i]),
      .rad_o  (ra_rad[i+1]),
      .root_o (ra_root[i+1]),
      .rem_o  (ra_rem[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQ; i++) va_r[i] <= 1'b0;
    end else if (en) begin
      va_r[0] <= v3_r;
      for (int i = 1; i < SQ; i++) va_r[i] <= va_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_dly_r[0] <= sa3_r;
      for (int i = 1; i < SQ; i++) sa_dly_r[i] <= sa_dly_r[i-1];
    end
  end

  // ---------------- eigenvalues and vector direction
  stea_pkg::side_a_t          sa;
  logic [stea_pkg::ROOT_W-1:0] s;
  logic [32:0]                t;
  logic [33:0]                tsum;
  logic signed [34:0]         tdif;
  logic signed [35:0]         x1, x2;
  logic [35:0]                x1m, x2m;

  logic                       v4_r;
  logic [32:0]                major4_r, t4_r;
  logic signed [32:0]         minor4_r;
  logic [stea_pkg::ROOT_W-1:0] s4_r;
  logic                       nx4_r, ny4_r, le4_r, fe4_r;
  logic [stea_pkg::MAG_W-1:0] mx4_r, my4_r;

  always_comb begin
    sa   = sa_dly_r[SQ-1];
    s    = ra_root[SQ];
    t    = 33'(sa.a) + 33'(sa.b);
    tsum = 34'(t) + 34'(s);
    tdif = $signed({2'b00, t}) - $signed({2'b00, s});
    x1   = 36'(sa.c) <<< 1;
    x2   = $signed({4'b0000, sa.b}) - $signed({4'b0000, sa.a}) - $signed({3'b000, s});
    x1m  = x1[35] ? (36'd0 - x1) : x1;
    x2m  = x2[35] ? (36'd0 - x2) : x2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      major4_r <= tsum[33:1];
      minor4_r <= tdif[33:1];
      s4_r     <= s;
      t4_r     <= t;
      nx4_r    <= x1[35];
      ny4_r    <= x2[35];
      mx4_r    <= x1m[stea_pkg::MAG_W-1:0];
      my4_r    <= x2m[stea_pkg::MAG_W-1:0];
      le4_r    <= sa.le;
      fe4_r    <= sa.fe;
    end
  end

  // scale both magnitudes below 2^31 together
  logic [stea_pkg::MAG_W-1:0] mor;
  logic [2:0]                 shamt;
  logic [stea_pkg::MAG_W-1:0] mxs, mys;
  stea_pkg::side_b_t          sb_in;

  always_comb begin
    mor = mx4_r | my4_r;
    if (mor[34])      shamt = 3'd4;
    else if (mor[33]) shamt = 3'd3;
    else if (mor[32]) shamt = 3'd2;
    else if (mor[31]) shamt = 3'd1;
    else              shamt = 3'd0;
    mxs = mx4_r >> shamt;
    mys = my4_r >> shamt;
    sb_in.major = major4_r;
    sb_in.minor = minor4_r;
    sb_in.s     = s4_r;
    sb_in.t     = t4_r;
    sb_in.nx    = nx4_r;
    sb_in.ny    = ny4_r;
    sb_in.mx    = mxs[stea_pkg::NORM_W-1:0];
    sb_in.my    = mys[stea_pkg::NORM_W-1:0];
    sb_in.le    = le4_r;
    sb_in.fe    = fe4_r;
  end

  logic              v5_r, v6_r, v7_r;
  stea_pkg::side_b_t sb5_r, sb6_r, sb7_r;
  logic [61:0]       mx2_r, my2_r;
  logic [62:0]       nsq7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v4_r <= va_r[SQ-1];
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb5_r  <= sb_in;
      sb6_r  <= sb5_r;
      mx2_r  <= 62'(sb5_r.mx) * 62'(sb5_r.mx);
      my2_r  <= 62'(sb5_r.my) * 62'(sb5_r.my);
      sb7_r  <= sb6_r;
      nsq7_r <= 63'(mx2_r) + 63'(my2_r);
    end
  end

  // ---------------- square root chain for the vector norm
  logic [stea_pkg::RAD_W-1:0]  rb_rad  [SQ+1];
  logic [stea_pkg::ROOT_W-1:0] rb_root [SQ+1];
  logic [stea_pkg::REM_W-1:0]  rb_rem  [SQ+1];
  stea_pkg::side_b_t           sb_dly_r [SQ];
  logic                        vb_r     [SQ];

  assign rb_rad[0]  = stea_pkg::RAD_W'(nsq7_r);
  assign rb_root[0] = '0;
  assign rb_rem[0]  = '0;

  for (genvar i = 0; i < SQ; i++) begin : g_sqb
    stea_sqrt_cell u_cell (
      .clk    (clk),
      .en     (en),
      .rad_i  (rb_rad[i]),
      .root_i (rb_root[i]),
      .rem_i  (rb_rem[i]),
      .rad_o  (rb_rad[i+1]),
      .root_o (rb_root[i+1]),
      .rem_o  (rb_rem[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQ; i++) vb_r[i] <= 1'b0;
    end else if (en) begin
      vb_r[0] <= v7_r;
      for (int i = 1; i < SQ; i++) vb_r[i] <= vb_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_dly_r[0] <= sb7_r;
      for (int i = 1; i < SQ; i++) sb_dly_r[i] <= sb_dly_r[i-1];
    end
  end

  // ---------------- divider setup
  stea_pkg::side_b_t          sb;
  stea_pkg::side_c_t          sc_in;
  logic [31:0]                nrm;
  logic [46:0]                numx, numy;

  always_comb begin
    sb   = sb_dly_r[SQ-1];
    nrm  = rb_root[SQ][31:0];
    numx = (47'(sb.mx) << 15) + 47'(nrm >> 1);
    numy = (47'(sb.my) << 15) + 47'(nrm >> 1);
    sc_in.major = sb.major;
    sc_in.minor = sb.minor;
    sc_in.nx    = sb.nx;
    sc_in.ny    = sb.ny;
    sc_in.nzero = (nrm == 32'd0);
    sc_in.le    = sb.le;
    sc_in.fe    = sb.fe;
    if (sb.t == 33'd0)                sc_in.mode = stea_pkg::ANIS_ZERO;
    else if (33'(sb.s) >= sb.t)       sc_in.mode = stea_pkg::ANIS_FULL;
    else                              sc_in.mode = stea_pkg::ANIS_DIV;
  end

  // lanes: 0 = eigvec_x, 1 = eigvec_y, 2 = anisotropy
  logic [stea_pkg::DIV_W-1:0] dl_rem [3][DV+1];
  logic [stea_pkg::Q_W-1:0]   dl_low [3][DV+1];
  logic [stea_pkg::DIV_W-1:0] dl_dvs [3][DV+1];
  logic [stea_pkg::Q_W-1:0]   dl_q   [3][DV+1];
  logic [stea_pkg::DIV_W-1:0] d0_rem_r [3];
  logic [stea_pkg::Q_W-1:0]   d0_low_r [3];
  logic [stea_pkg::DIV_W-1:0] d0_dvs_r [3];
  logic                       v8_r;
  stea_pkg::side_c_t          sc8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else if (en) begin
      v8_r <= vb_r[SQ-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc8_r       <= sc_in;
      d0_rem_r[0] <= stea_pkg::DIV_W'(numx[46:16]);
      d0_low_r[0] <= numx[15:0];
      d0_dvs_r[0] <= stea_pkg::DIV_W'(nrm);
      d0_rem_r[1] <= stea_pkg::DIV_W'(numy[46:16]);
      d0_low_r[1] <= numy[15:0];
      d0_dvs_r[1] <= stea_pkg::DIV_W'(nrm);
      d0_rem_r[2] <= stea_pkg::DIV_W'(sb.s);
      d0_low_r[2] <= '0;
      d0_dvs_r[2] <= stea_pkg::DIV_W'(sb.t);
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign dl_rem[l][0] = d0_rem_r[l];
    assign dl_low[l][0] = d0_low_r[l];
    assign dl_dvs[l][0] = d0_dvs_r[l];
    assign dl_q[l][0]   = '0;
    for (genvar i = 0; i < DV; i++) begin : g_div
      stea_div_cell u_cell (
        .clk   (clk),
        .en    (en),
        .rem_i (dl_rem[l][i]),
        .low_i (dl_low[l][i]),
        .dvs_i (dl_dvs[l][i]),
        .q_i   (dl_q[l][i]),
        .rem_o (dl_rem[l][i+1]),
        .low_o (dl_low[l][i+1]),
        .dvs_o (dl_dvs[l][i+1]),
        .q_o   (dl_q[l][i+1])
      );
    end
  end

  stea_pkg::side_c_t sc_dly_r [DV];
  logic              vc_r     [DV];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DV; i++) vc_r[i] <= 1'b0;
    end else if (en) begin
      vc_r[0] <= v8_r;
      for (int i = 1; i < DV; i++) vc_r[i] <= vc_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_dly_r[0] <= sc8_r;
      for (int i = 1; i < DV; i++) sc_dly_r[i] <= sc_dly_r[i-1];
    end
  end

  // ---------------- result assembly
  stea_pkg::side_c_t          sc;
  logic [stea_pkg::Q_W-1:0]   qx, qy;
  logic [stea_pkg::VEC_W-1:0] ex, ey;
  logic [stea_pkg::ANIS_W-1:0] anis;
  logic                       up_v;

  always_comb begin
    sc = sc_dly_r[DV-1];
    qx = (dl_q[0][DV] > 16'd32767) ? 16'd32767 : dl_q[0][DV];
    qy = (dl_q[1][DV] > 16'd32767) ? 16'd32767 : dl_q[1][DV];
    ex = sc.nzero ? 16'd0 : (sc.nx ? (16'd0 - qx) : qx);
    ey = sc.nzero ? 16'd0 : (sc.ny ? (16'd0 - qy) : qy);
    case (sc.mode)
      stea_pkg::ANIS_ZERO: anis = '0;
      stea_pkg::ANIS_FULL: anis = 17'h10000;
      stea_pkg::ANIS_DIV:  anis = {1'b0, dl_q[2][DV]};
      default:             anis = '0;
    endcase
    up_rec.data = {5'b00000, ey, ex, anis, sc.minor, sc.major};
    up_rec.le   = sc.le;
    up_rec.fe   = sc.fe;
    up_v        = vc_r[DV-1];
  end

  // ---------------- output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_tready || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= up_v;
      end
    end else if (up_v && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_v_r) begin
      out_rec_r <= skid_v_r ? skid_rec_r : up_rec;
    end else if (en) begin
      skid_rec_r <= up_rec;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_rec_r.data;
  assign out_tlast  = out_rec_r.le;
  assign out_tuser  = out_rec_r.fe;

endmodule
